FILE: src/tbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracked blob table package
// Entry layout, result codes, action codes and controller states shared by
// the blob table files.
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_FRAME  = 1'b1;

  typedef enum logic [1:0] {
    STAT_UPDATED  = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_SWEPT    = 2'd3
  } tbt_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } tbt_state_t;

  // One table slot as held in the memory. Box is {h, w, y, x}, x in the low
  // bits; birth position is {y, x}.
  typedef struct packed {
    logic        valid;
    logic        seen;
    logic        counted;
    logic [15:0] key;
    logic [39:0] box;
    logic [31:0] birth_time;
    logic [19:0] birth_pos;
  } tbt_entry_t;

  localparam int unsigned ENTRY_W = $bits(tbt_entry_t);

endpackage

FILE: src/tbt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob table input channel
// Valid/ready channel carrying blob reports and frame marks.
// ----------------------------------------------------------------------------
interface tbt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  client;
  logic [15:0] blob_id;
  logic [9:0]  pos_x;
  logic [9:0]  pos_y;
  logic [9:0]  box_w;
  logic [9:0]  box_h;
  logic [31:0] time_ms;

  modport source (
    output valid, action, client, blob_id, pos_x, pos_y, box_w, box_h, time_ms,
    input  ready
  );

  modport sink (
    input  valid, action, client, blob_id, pos_x, pos_y, box_w, box_h, time_ms,
    output ready
  );
endinterface

FILE: src/tbt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob table result channel
// Valid/ready channel carrying one result item per input item.
// ----------------------------------------------------------------------------
interface tbt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] removed_count;
  logic [4:0] occupied_count;

  modport source (
    output valid, status, removed_count, occupied_count,
    input  ready
  );

  modport sink (
    input  valid, status, removed_count, occupied_count,
    output ready
  );
endinterface

FILE: src/tbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob table memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tbt_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tracked_blob_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracked blob table core
// Per-client table of tracked blobs keyed by blob id, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries blob reports (action 0) and frame marks (action 1) for one
//   client partition. out_ch returns exactly one result item per input item:
//   status, entries removed by a frame mark and the partition's occupancy.
//   Each item walks the TABLE_SLOTS entries of its partition through the
//   single table RAM, one read per cycle, followed by a drain step and a
//   commit step. An item for a client outside the partitions skips the walk
//   and goes straight from accept to commit. Items are worked one at a time.
//   The result sits in an output register: the next item is accepted while
//   it waits, and only the commit of that next item waits for the receiver.
//   After reset the block clears the valid bit of every entry, one entry per
//   cycle; in_ch.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module tracked_blob_table_core #(
  parameter int CLIENTS     = 4,
  parameter int TABLE_SLOTS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  tbt_in_if.sink    in_ch,
  tbt_out_if.source out_ch
);
  import tbt_pkg::*;

  localparam int ALL_SLOTS = CLIENTS * TABLE_SLOTS;
  localparam int AW        = (ALL_SLOTS > 1) ? $clog2(ALL_SLOTS) : 1;
  localparam int SW        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW        = $clog2(TABLE_SLOTS + 1);

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] c,
                                               input logic [SW-1:0] s);
    return AW'(int'(c) * TABLE_SLOTS + int'(s));
  endfunction

  function automatic logic [4:0] sat5(input logic [CW-1:0] n);
    return (int'(n) > 31) ? 5'd31 : 5'(n);
  endfunction

  tbt_state_t state_r, state_nxt;

  logic          act_r, act_nxt;
  logic [1:0]    client_r, client_nxt;
  logic [15:0]   key_r, key_nxt;
  logic [39:0]   box_r, box_nxt;
  logic [31:0]   time_r, time_nxt;
  logic [19:0]   pos_r, pos_nxt;
  logic          bad_r, bad_nxt;

  logic [SW-1:0] slot_r, slot_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [SW-1:0] rd_slot_r, rd_slot_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [CW-1:0] vcount_r, vcount_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] hit_slot_r, hit_slot_nxt;
  tbt_entry_t    hit_ent_r, hit_ent_nxt;
  logic          free_r, free_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;

  logic          out_valid_r, out_valid_nxt;
  tbt_status_t   out_status_r, out_status_nxt;
  logic [4:0]    out_removed_r, out_removed_nxt;
  logic [4:0]    out_occ_r, out_occ_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  tbt_entry_t       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  tbt_entry_t       rd_ent;

  assign rd_ent = tbt_entry_t'(mem_rdata);

  tbt_ram #(
    .DEPTH (ALL_SLOTS),
    .AW    (AW),
    .DW    (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    client_nxt      = client_r;
    key_nxt         = key_r;
    box_nxt         = box_r;
    time_nxt        = time_r;
    pos_nxt         = pos_r;
    bad_nxt         = bad_r;
    slot_nxt        = slot_r;
    rd_pend_nxt     = 1'b0;
    rd_slot_nxt     = rd_slot_r;
    clr_addr_nxt    = clr_addr_r;
    vcount_nxt      = vcount_r;
    removed_nxt     = removed_r;
    hit_nxt         = hit_r;
    hit_slot_nxt    = hit_slot_r;
    hit_ent_nxt     = hit_ent_r;
    free_nxt        = free_r;
    free_slot_nxt   = free_slot_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;
    in_ch.ready     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = slot_addr(client_r, rd_slot_r);
    mem_wdata       = rd_ent;
    mem_raddr       = slot_addr(client_r, slot_r);

    // Entry returned by the read issued in the previous cycle.
    if (rd_pend_r) begin
      if (act_r == ACT_FRAME) begin
        if (rd_ent.valid) begin
          mem_we = 1'b1;
          if (!rd_ent.seen) begin
            mem_wdata.valid = 1'b0;
            removed_nxt     = removed_r + 1'b1;
          end else begin
            mem_wdata.seen = 1'b0;
            vcount_nxt     = vcount_r + 1'b1;
          end
        end
      end else begin
        if (rd_ent.valid) begin
          vcount_nxt = vcount_r + 1'b1;
          if (!hit_r && rd_ent.key == key_r) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = rd_slot_r;
            hit_ent_nxt  = rd_ent;
          end
        end else if (!free_r) begin
          free_nxt      = 1'b1;
          free_slot_nxt = rd_slot_r;
        end
      end
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(ALL_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          act_nxt     = in_ch.action;
          client_nxt  = in_ch.client;
          key_nxt     = in_ch.blob_id;
          box_nxt     = {in_ch.box_h, in_ch.box_w, in_ch.pos_y, in_ch.pos_x};
          time_nxt    = in_ch.time_ms;
          pos_nxt     = {in_ch.pos_y, in_ch.pos_x};
          bad_nxt     = int'(in_ch.client) >= CLIENTS;
          slot_nxt    = '0;
          vcount_nxt  = '0;
          removed_nxt = '0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          state_nxt   = (int'(in_ch.client) >= CLIENTS) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        rd_pend_nxt = 1'b1;
        rd_slot_nxt = slot_r;
        if (slot_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = '0;
          out_occ_nxt     = sat5(vcount_r);
          state_nxt       = ST_IDLE;
          if (bad_r) begin
            out_status_nxt = (act_r == ACT_FRAME) ? STAT_SWEPT : STAT_DROPPED;
            out_occ_nxt    = '0;
          end else if (act_r == ACT_FRAME) begin
            out_status_nxt  = STAT_SWEPT;
            out_removed_nxt = sat5(removed_r);
          end else if (hit_r) begin
            out_status_nxt = STAT_UPDATED;
            mem_we         = 1'b1;
            mem_waddr      = slot_addr(client_r, hit_slot_r);
            mem_wdata      = hit_ent_r;
            mem_wdata.box  = box_r;
            mem_wdata.seen = 1'b1;
          end else if (free_r) begin
            out_status_nxt       = STAT_INSERTED;
            out_occ_nxt          = sat5(vcount_r + 1'b1);
            mem_we               = 1'b1;
            mem_waddr            = slot_addr(client_r, free_slot_r);
            mem_wdata.valid      = 1'b1;
            mem_wdata.seen       = 1'b1;
            mem_wdata.counted    = 1'b0;
            mem_wdata.key        = key_r;
            mem_wdata.box        = box_r;
            mem_wdata.birth_time = time_r;
            mem_wdata.birth_pos  = pos_r;
          end else begin
            out_status_nxt = STAT_DROPPED;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    client_r      <= client_nxt;
    key_r         <= key_nxt;
    box_r         <= box_nxt;
    time_r        <= time_nxt;
    pos_r         <= pos_nxt;
    bad_r         <= bad_nxt;
    slot_r        <= slot_nxt;
    rd_slot_r     <= rd_slot_nxt;
    vcount_r      <= vcount_nxt;
    removed_r     <= removed_nxt;
    hit_r         <= hit_nxt;
    hit_slot_r    <= hit_slot_nxt;
    hit_ent_r     <= hit_ent_nxt;
    free_r        <= free_nxt;
    free_slot_r   <= free_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.removed_count  = out_removed_r;
  assign out_ch.occupied_count = out_occ_r;

  // A frame write-back during the walk must never hit the entry being read.
  a_walk_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && mem_we) |-> (mem_waddr != mem_raddr))
    else $error("walk write-back collides with walk read");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in work");

  // Only frame marks remove entries.
  a_removed_frame_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STAT_SWEPT) |-> (out_ch.removed_count == 5'd0))
    else $error("removed count on a report result");

  // An insert leaves at least one occupied entry.
  a_insert_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STAT_INSERTED) |-> (out_ch.occupied_count != 5'd0))
    else $error("insert reported with empty partition");

  // A free slot was found, so the partition cannot have been full.
  a_free_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && free_r && !bad_r && act_r == ACT_REPORT)
      |-> (int'(vcount_r) < TABLE_SLOTS))
    else $error("free slot found in a full partition");

endmodule
